// File: hdl/vrsu_pkg.sv
// ----------------------------------------------------------------------------
// vrsu_pkg
// Shared types and constants for the video register and scroll unit.
// ----------------------------------------------------------------------------
package vrsu_pkg;

  localparam int unsigned OamBytes       = 256;
  localparam int unsigned PaletteEntries = 32;

  typedef enum logic [3:0] {
    OP_REG_WR   = 4'd0,
    OP_REG_RD   = 4'd1,
    OP_DMA      = 4'd2,
    OP_TILE     = 4'd3,
    OP_LINE_END = 4'd4,
    OP_LINE_RLD = 4'd5,
    OP_FRAME    = 4'd6,
    OP_VBLANK   = 4'd7,
    OP_SPRITE0  = 4'd8
  } op_e;

  localparam logic [2:0] REG_CTRL   = 3'd0;
  localparam logic [2:0] REG_MASK   = 3'd1;
  localparam logic [2:0] REG_STATUS = 3'd2;
  localparam logic [2:0] REG_OAMADR = 3'd3;
  localparam logic [2:0] REG_OAMDAT = 3'd4;
  localparam logic [2:0] REG_SCROLL = 3'd5;
  localparam logic [2:0] REG_ADDR   = 3'd6;
  localparam logic [2:0] REG_DATA   = 3'd7;

  localparam logic [5:0]  PalettePage = 6'h3f;
  localparam logic [14:0] NtFlipH     = 15'h0400;
  localparam logic [14:0] NtFlipV     = 15'h0800;
  localparam logic [14:0] FineYStep   = 15'h1000;
  localparam logic [14:0] ReloadMask  = 15'h041f;
  localparam logic [4:0]  CoarseYLast = 5'd29;
  localparam logic [7:0]  Unreadable  = 8'hff;

  typedef struct packed {
    logic [3:0] opcode;
    logic [2:0] reg_sel;
    logic [7:0] data;
    logic [7:0] dma_index;
  } item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        read_from_vram;
    logic [13:0] vram_addr;
    logic        vram_write;
    logic [7:0]  vram_write_data;
    logic        nmi;
    logic [14:0] scroll_addr;
    logic [2:0]  fine_scroll_x;
  } res_t;

endpackage

// File: hdl/vrsu_in_if.sv
// ----------------------------------------------------------------------------
// vrsu_in_if
// Input item channel: bus access, OAM DMA byte or render event.
// ----------------------------------------------------------------------------
interface vrsu_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] opcode;
  logic [2:0] reg_sel;
  logic [7:0] data;
  logic [7:0] dma_index;

  modport source (output valid, opcode, reg_sel, data, dma_index, input ready);
  modport sink   (input valid, opcode, reg_sel, data, dma_index, output ready);
endinterface

// File: hdl/vrsu_out_if.sv
// ----------------------------------------------------------------------------
// vrsu_out_if
// Result item channel.
// ----------------------------------------------------------------------------
interface vrsu_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic        read_from_vram;
  logic [13:0] vram_addr;
  logic        vram_write;
  logic [7:0]  vram_write_data;
  logic        nmi;
  logic [14:0] scroll_addr;
  logic [2:0]  fine_scroll_x;

  modport source (output valid, read_data, read_from_vram, vram_addr, vram_write,
                  vram_write_data, nmi, scroll_addr, fine_scroll_x, input ready);
  modport sink   (input valid, read_data, read_from_vram, vram_addr, vram_write,
                  vram_write_data, nmi, scroll_addr, fine_scroll_x, output ready);
endinterface

// File: hdl/video_register_scroll_unit.sv
// ----------------------------------------------------------------------------
// video_register_scroll_unit
// Picture-unit register file and scroll-address unit.
//
// item_i carries one bus register access, one OAM DMA byte or one render
// event; result_o returns exactly one result item for each, in order.
// Data-port accesses below the palette page come out as external requests
// (read_from_vram / vram_write at vram_addr); palette and OAM are internal.
// An accepted item is held in the input register, is processed there,
// and lands in the result register; one item per cycle is sustained while
// result_o does not stall. The OAM read is issued from the sprite
// RAM port as the item is accepted, with bypass from the write in flight.
// When result_o stalls, the result register holds and the input register
// keeps one more item; item_i.ready drops only while both are full.
// Reset clears the palette, the OAM valid bits and all control state, not
// the item or result data; OAM reads zero until written; ready after reset.
// ----------------------------------------------------------------------------
module video_register_scroll_unit
  import vrsu_pkg::*;
#(
  parameter int unsigned OAM_BYTES       = OamBytes,
  parameter int unsigned PALETTE_ENTRIES = PaletteEntries
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  vrsu_in_if.sink    item_i,
  vrsu_out_if.source result_o
);

  localparam int unsigned OamAw = $clog2(OAM_BYTES);
  localparam int unsigned PalAw = $clog2(PALETTE_ENTRIES);

  // handshake
  logic  in_valid, in_ready, in_acc, out_ready, out_free, adv;
  logic  s1_valid_q, out_valid_q;
  item_t s1_q, item_in;
  res_t  res_q, res_d;

  // architectural state
  logic [7:0]       ctrl_q, ctrl_d, mask_q, mask_d, status_q, status_d;
  logic [OamAw-1:0] oam_ptr_q, oam_ptr_d;
  logic [14:0]      t_q, t_d, v_q, v_d;
  logic [2:0]       fx_q, fx_d;
  logic             w_q, w_d;
  logic [7:0]       pal_q [PALETTE_ENTRIES];
  logic [OAM_BYTES-1:0] spr_vld_q;

  // sprite RAM side
  logic             spr_we, ram_we;
  logic [OamAw-1:0] spr_waddr, spr_raddr;
  logic [7:0]       ram_rdata, spr_rd;
  logic             sp_fwd_q, sp_vld_q;
  logic [7:0]       sp_fwd_data_q;

  // palette write
  logic             pal_we;
  logic [PalAw-1:0] pal_idx;
  logic             pal_twin;

  // datapath helpers
  logic [13:0] a14;
  logic        ext_port;
  logic [14:0] v_inc, v_cx, v_y, t_wr;
  logic [4:0]  cy;

  assign in_valid            = item_i.valid;
  assign item_in.opcode      = item_i.opcode;
  assign item_in.reg_sel     = item_i.reg_sel;
  assign item_in.data        = item_i.data;
  assign item_in.dma_index   = item_i.dma_index;
  assign out_ready           = result_o.ready;

  assign out_free = !out_valid_q || out_ready;
  assign adv      = s1_valid_q && out_free;
  assign in_ready = !s1_valid_q || adv;
  assign in_acc   = in_valid && in_ready;
  assign item_i.ready = in_ready;

  assign a14      = v_q[13:0];
  assign ext_port = a14[13:8] != PalettePage;
  assign v_inc    = v_q + (ctrl_q[2] ? 15'd32 : 15'd1);
  assign v_cx     = (v_q[4:0] == 5'd31) ? ({v_q[14:5], 5'd0} ^ NtFlipH) : v_q + 15'd1;
  assign spr_rd   = sp_fwd_q ? sp_fwd_data_q : (sp_vld_q ? ram_rdata : 8'd0);

  always_comb begin
    cy = v_q[9:5];
    if (v_q[14:12] != 3'd7) begin
      v_y = v_q + FineYStep;
    end else begin
      v_y = {3'd0, v_q[11:0]};
      if (cy == CoarseYLast) begin
        cy  = 5'd0;
        v_y = v_y ^ NtFlipV;
      end else if (cy == 5'd31) begin
        cy = 5'd0;
      end else begin
        cy = cy + 5'd1;
      end
      v_y[9:5] = cy;
    end
  end

  always_comb begin
    ctrl_d    = ctrl_q;
    mask_d    = mask_q;
    status_d  = status_q;
    oam_ptr_d = oam_ptr_q;
    t_d       = t_q;
    v_d       = v_q;
    fx_d      = fx_q;
    w_d       = w_q;
    t_wr      = {t_q[14:8], s1_q.data};
    spr_we    = 1'b0;
    spr_waddr = oam_ptr_q;
    pal_we    = 1'b0;
    pal_idx   = a14[PalAw-1:0];
    pal_twin  = a14[1:0] == 2'd0;
    res_d     = '0;
    case (s1_q.opcode)
      OP_REG_WR: begin
        case (s1_q.reg_sel)
          REG_CTRL: begin
            ctrl_d       = s1_q.data;
            t_d[11:10]   = s1_q.data[1:0];
          end
          REG_MASK:   mask_d    = s1_q.data;
          REG_STATUS: status_d  = s1_q.data;
          REG_OAMADR: oam_ptr_d = s1_q.data[OamAw-1:0];
          REG_OAMDAT: begin
            spr_we    = 1'b1;
            oam_ptr_d = oam_ptr_q + 1'b1;
          end
          REG_SCROLL: begin
            if (!w_q) begin
              t_d[4:0] = s1_q.data[7:3];
              fx_d     = s1_q.data[2:0];
            end else begin
              t_d[14:12] = s1_q.data[2:0];
              t_d[9:5]   = s1_q.data[7:3];
            end
            w_d = !w_q;
          end
          REG_ADDR: begin
            if (!w_q) begin
              t_d = {1'b0, s1_q.data[5:0], t_q[7:0]};
            end else begin
              t_d = t_wr;
              v_d = t_wr;
            end
            w_d = !w_q;
          end
          default: begin
            if (ext_port) begin
              res_d.vram_write      = 1'b1;
              res_d.vram_addr       = a14;
              res_d.vram_write_data = s1_q.data;
            end else begin
              pal_we = 1'b1;
            end
            v_d = v_inc;
          end
        endcase
      end
      OP_REG_RD: begin
        res_d.read_data = Unreadable;
        case (s1_q.reg_sel)
          REG_STATUS: begin
            res_d.read_data = status_q;
            status_d        = {2'b00, status_q[5:0]};
            w_d             = 1'b0;
          end
          REG_OAMDAT: res_d.read_data = spr_rd;
          REG_DATA: begin
            if (ext_port) begin
              res_d.read_from_vram = 1'b1;
              res_d.vram_addr      = a14;
              res_d.read_data      = 8'd0;
            end else begin
              res_d.read_data = pal_q[a14[PalAw-1:0]];
            end
            if (!w_q) begin
              w_d = 1'b1;
            end else begin
              v_d = v_inc;
            end
          end
          default: ;
        endcase
      end
      OP_DMA: begin
        spr_we    = 1'b1;
        spr_waddr = s1_q.dma_index[OamAw-1:0];
      end
      OP_TILE: begin
        if (mask_q[3]) v_d = v_cx;
      end
      OP_LINE_END: begin
        if (mask_q[3]) v_d = v_y;
      end
      OP_LINE_RLD: begin
        if (mask_q[3]) v_d = (v_q & ~ReloadMask) | (t_q & ReloadMask);
      end
      OP_FRAME: begin
        status_d = {3'b000, status_q[4:0]};
        if (mask_q[3]) v_d = t_q;
      end
      OP_VBLANK: begin
        status_d[7] = 1'b1;
        res_d.nmi   = ctrl_q[7];
      end
      OP_SPRITE0: status_d[6] = 1'b1;
      default: ;
    endcase
    res_d.scroll_addr   = v_d;
    res_d.fine_scroll_x = fx_d;
  end

  assign ram_we    = adv && spr_we;
  assign spr_raddr = adv ? oam_ptr_d : oam_ptr_q;

  vrsu_ram #(
    .Width(8),
    .Depth(OAM_BYTES)
  ) u_vrsu_oam (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(spr_waddr),
    .wdata_i(s1_q.data),
    .re_i   (in_acc),
    .raddr_i(spr_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ctrl_q      <= '0;
      mask_q      <= '0;
      status_q    <= '0;
      oam_ptr_q   <= '0;
      t_q         <= '0;
      v_q         <= '0;
      fx_q        <= '0;
      w_q         <= 1'b0;
      spr_vld_q   <= '0;
      sp_fwd_q    <= 1'b0;
      sp_vld_q    <= 1'b0;
      for (int i = 0; i < PALETTE_ENTRIES; i++) begin
        pal_q[i] <= '0;
      end
    end else begin
      if (in_ready) s1_valid_q <= in_valid;
      if (out_free) out_valid_q <= s1_valid_q;
      if (in_acc) begin
        sp_fwd_q <= ram_we && (spr_waddr == spr_raddr);
        sp_vld_q <= spr_vld_q[spr_raddr];
      end
      if (adv) begin
        ctrl_q    <= ctrl_d;
        mask_q    <= mask_d;
        status_q  <= status_d;
        oam_ptr_q <= oam_ptr_d;
        t_q       <= t_d;
        v_q       <= v_d;
        fx_q      <= fx_d;
        w_q       <= w_d;
        if (spr_we) spr_vld_q[spr_waddr] <= 1'b1;
        for (int i = 0; i < PALETTE_ENTRIES; i++) begin
          if (pal_we && (PalAw'(i) == pal_idx ||
              (pal_twin && PalAw'(i) % (PALETTE_ENTRIES / 2) ==
               pal_idx % (PALETTE_ENTRIES / 2)))) begin
            pal_q[i] <= s1_q.data;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q          <= item_in;
      sp_fwd_data_q <= s1_q.data;
    end
    if (adv) res_q <= res_d;
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.read_data       = res_q.read_data;
  assign result_o.read_from_vram  = res_q.read_from_vram;
  assign result_o.vram_addr       = res_q.vram_addr;
  assign result_o.vram_write      = res_q.vram_write;
  assign result_o.vram_write_data = res_q.vram_write_data;
  assign result_o.nmi             = res_q.nmi;
  assign result_o.scroll_addr     = res_q.scroll_addr;
  assign result_o.fine_scroll_x   = res_q.fine_scroll_x;

endmodule

// File: hdl/vrsu_ram.sv
// ----------------------------------------------------------------------------
// vrsu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vrsu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/vrsu_checker.sv
// ----------------------------------------------------------------------------
// vrsu_checker
// Port-level checks for the video register and scroll unit.
// ----------------------------------------------------------------------------
module vrsu_checker
  import vrsu_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input res_t res_i
);

  // input side only backs up when both the input and result registers are full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("item stalled without result backpressure");

  // an accepted item shows a valid result after the input and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> ##1 out_valid_i)
    else $error("result missing after accepted item");

  // an external read and an external write never share a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(res_i.read_from_vram && res_i.vram_write))
    else $error("external read and write in one result");

  // external read carries zero read data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && res_i.read_from_vram |-> res_i.read_data == 8'd0)
    else $error("external read with nonzero read data");

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(res_i))
    else $error("stalled result changed");

endmodule

bind video_register_scroll_unit vrsu_checker u_vrsu_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid),
  .in_ready_i (in_ready),
  .out_valid_i(out_valid_q),
  .out_ready_i(out_ready),
  .res_i      (res_q)
);
